### rtl/rgb_hue_shift_brightness_top_defines.svh
// assertion macros for the hue shift and brightness block
`ifndef RGB_HUE_SHIFT_BRIGHTNESS_TOP_DEFINES_SVH
`define RGB_HUE_SHIFT_BRIGHTNESS_TOP_DEFINES_SVH
`ifndef SYNTH
`define RHSB_CHECK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rhsb assertion failed");
`define RHSB_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhsb assertion failed");
`else
`define RHSB_CHECK(lbl, clk, rst_n, prop)
`define RHSB_CHECK_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/rhsb_pkg.sv
package rhsb_pkg;

    localparam int CH_BITS   = 8;
    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = 24;

    localparam logic [16:0] FRAC_ONE   = 17'd65536;
    localparam logic [12:0] HUE_FULL   = 13'd5760;
    localparam logic [9:0]  HUE_SECTOR = 10'd960;
    // ceil(2^23 / 15), turns rem * 1024 / 15 into a multiply and shift
    localparam logic [19:0] RECIP_15   = 20'd559241;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HUE_OFFSET      = 2'd0;
    localparam t_cfg_idx CFG_BRIGHTNESS_GAIN = 2'd1;

    typedef enum logic [1:0] {
        HB_RED,
        HB_GREEN,
        HB_BLUE
    } t_hue_base;

    typedef enum logic [2:0] {
        SEC_0,
        SEC_1,
        SEC_2,
        SEC_3,
        SEC_4,
        SEC_5
    } t_sector;

    typedef struct packed {
        logic [CH_BITS-1:0] mx;
        logic               mx_zero;
        logic               d_zero;
        t_hue_base          base;
        logic               neg;
    } t_div_side;

endpackage

### rtl/rhsb_pix_in_if.sv
interface rhsb_pix_in_if;
    logic                          valid;
    logic                          ready;
    logic [rhsb_pkg::CH_BITS-1:0]  red_in;
    logic [rhsb_pkg::CH_BITS-1:0]  green_in;
    logic [rhsb_pkg::CH_BITS-1:0]  blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

### rtl/rhsb_pix_out_if.sv
interface rhsb_pix_out_if;
    logic                          valid;
    logic                          ready;
    logic [rhsb_pkg::CH_BITS-1:0]  red_out;
    logic [rhsb_pkg::CH_BITS-1:0]  green_out;
    logic [rhsb_pkg::CH_BITS-1:0]  blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

### rtl/rhsb_div.sv
// pipelined restoring divider, one quotient bit per stage
module rhsb_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] w_rem [0:NUM_W];
    logic [NUM_W-1:0] w_num [0:NUM_W];
    logic [NUM_W-1:0] w_quo [0:NUM_W];
    logic [DEN_W-1:0] w_den [0:NUM_W];

    assign w_rem[0] = '0;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;

    for (genvar j = 0; j < NUM_W; j++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] r_rem;
        logic [NUM_W-1:0] r_num;
        logic [NUM_W-1:0] r_quo;
        logic [DEN_W-1:0] r_den;

        assign trial = {w_rem[j], w_num[j][NUM_W-1]};
        assign ge    = (trial >= {1'b0, w_den[j]});
        assign diff  = trial - {1'b0, w_den[j]};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_num <= {w_num[j][NUM_W-2:0], 1'b0};
                r_quo <= {w_quo[j][NUM_W-2:0], ge};
                r_den <= w_den[j];
            end
        end

        assign w_rem[j+1] = r_rem;
        assign w_num[j+1] = r_num;
        assign w_quo[j+1] = r_quo;
        assign w_den[j+1] = r_den;
    end

    assign o_quo = w_quo[NUM_W];

endmodule

### rtl/rgb_hue_shift_brightness_top.sv
// input transfer to result: prep register, divider pipelines, h1 to h5, output register
// throughput: one pixel per cycle unless stalled; the 24-stage divider pipelines set the depth
// the whole pipeline advances together; it stalls only while a result waits at the output
// reset: synchronous active low; clears all stage valid bits, hue offset to 0,
// brightness gain to 256 (unity)
module rgb_hue_shift_brightness_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    rhsb_pix_in_if.sink           i_pix,
    rhsb_pix_out_if.source        o_pix
);

    `include "rgb_hue_shift_brightness_top_defines.svh"

    localparam int CB = rhsb_pkg::CH_BITS;
    localparam int DW = rhsb_pkg::DIV_W;

    // configuration registers
    logic signed [13:0] r_hue_offset;
    logic [15:0]        r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_offset <= '0;
            r_gain       <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rhsb_pkg::CFG_HUE_OFFSET:      r_hue_offset <= i_cfg_data[13:0];
                rhsb_pkg::CFG_BRIGHTNESS_GAIN: r_gain       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global pipeline advance: everything moves unless the output holds a result
    logic r_out_vld;
    logic w_ce;
    assign w_ce        = !r_out_vld || o_pix.ready;
    assign i_pix.ready = w_ce;

    // ---------------- stage 1: max, min, delta, hue numerator ----------------
    logic [CB-1:0]       w_r, w_g, w_b, w_mx, w_mn;
    logic signed [CB:0]  w_num;
    logic [CB-1:0]       w_abs;
    rhsb_pkg::t_hue_base w_base;

    assign w_r = i_pix.red_in;
    assign w_g = i_pix.green_in;
    assign w_b = i_pix.blue_in;

    always_comb begin
        w_mx = (w_r > w_g) ? w_r : w_g;
        w_mn = (w_r < w_g) ? w_r : w_g;
        if (w_b > w_mx) w_mx = w_b;
        if (w_b < w_mn) w_mn = w_b;
        // same priority as the usual rule: red wins ties, then green
        if (w_r == w_mx) begin
            w_base = rhsb_pkg::HB_RED;
            w_num  = $signed({1'b0, w_g}) - $signed({1'b0, w_b});
        end else if (w_g == w_mx) begin
            w_base = rhsb_pkg::HB_GREEN;
            w_num  = $signed({1'b0, w_b}) - $signed({1'b0, w_r});
        end else begin
            w_base = rhsb_pkg::HB_BLUE;
            w_num  = $signed({1'b0, w_r}) - $signed({1'b0, w_g});
        end
        w_abs = w_num[CB] ? CB'(-w_num) : w_num[CB-1:0];
    end

    logic                r_s1_vld;
    logic [CB-1:0]       r_s1_mx;
    logic [CB-1:0]       r_s1_d;
    logic [17:0]         r_s1_hnum;
    logic                r_s1_neg;
    rhsb_pkg::t_hue_base r_s1_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_vld <= 1'b0;
        else if (w_ce) r_s1_vld <= i_pix.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s1_mx   <= w_mx;
            r_s1_d    <= w_mx - w_mn;
            // |num| * 960, truncation toward zero handled by dividing the magnitude
            r_s1_hnum <= 18'(w_abs) * 18'(rhsb_pkg::HUE_SECTOR);
            r_s1_neg  <= w_num[CB];
            r_s1_base <= w_base;
        end
    end

    // ---------------- divider pipelines: saturation and hue ----------------
    logic [DW-1:0] w_sat_quo;
    logic [DW-1:0] w_hue_quo;

    rhsb_div #(.NUM_W(DW), .DEN_W(CB)) u_sat_div (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num ({r_s1_d, 16'd0}),
        .i_den (r_s1_mx),
        .o_quo (w_sat_quo)
    );

    rhsb_div #(.NUM_W(DW), .DEN_W(CB)) u_hue_div (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num ({6'd0, r_s1_hnum}),
        .i_den (r_s1_d),
        .o_quo (w_hue_quo)
    );

    // sideband shift line riding alongside the dividers
    logic                  r_dv_vld [0:DW-1];
    rhsb_pkg::t_div_side   r_dv_sb  [0:DW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DW; j++) r_dv_vld[j] <= 1'b0;
        end else if (w_ce) begin
            r_dv_vld[0] <= r_s1_vld;
            for (int j = 1; j < DW; j++) r_dv_vld[j] <= r_dv_vld[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_dv_sb[0].mx      <= r_s1_mx;
            r_dv_sb[0].mx_zero <= (r_s1_mx == '0);
            r_dv_sb[0].d_zero  <= (r_s1_d == '0);
            r_dv_sb[0].base    <= r_s1_base;
            r_dv_sb[0].neg     <= r_s1_neg;
            for (int j = 1; j < DW; j++) r_dv_sb[j] <= r_dv_sb[j-1];
        end
    end

    // ---------------- h1: hue assembly, offset, wrap ----------------
    rhsb_pkg::t_div_side w_sb;
    logic signed [15:0]  w_hq, w_hv, w_hs;
    logic [12:0]         n_h1_hue;

    assign w_sb = r_dv_sb[DW-1];
    assign w_hq = $signed({6'd0, w_hue_quo[9:0]});

    always_comb begin
        case (w_sb.base)
            rhsb_pkg::HB_GREEN: w_hv = 16'sd1920;
            rhsb_pkg::HB_BLUE:  w_hv = 16'sd3840;
            default:            w_hv = 16'sd0;
        endcase
        w_hv = w_sb.neg ? (w_hv - w_hq) : (w_hv + w_hq);
        if (w_hv < 0) w_hv = w_hv + 16'sd5760;
        // gray pixel has hue 0
        if (w_sb.d_zero) w_hv = '0;
        w_hs = w_hv + 16'(r_hue_offset);
        // bring the shifted hue into 0..5759
        if (w_hs < -16'sd5760)      w_hs = w_hs + 16'sd11520;
        else if (w_hs < 0)          w_hs = w_hs + 16'sd5760;
        else if (w_hs >= 16'sd11520) w_hs = w_hs - 16'sd11520;
        else if (w_hs >= 16'sd5760)  w_hs = w_hs - 16'sd5760;
        n_h1_hue = w_hs[12:0];
    end

    logic          r_h1_vld;
    logic [12:0]   r_h1_hue;
    logic [16:0]   r_h1_s;
    logic [CB-1:0] r_h1_mx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h1_vld <= 1'b0;
        else if (w_ce) r_h1_vld <= r_dv_vld[DW-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_h1_hue <= n_h1_hue;
            // black pixel has saturation 0
            r_h1_s   <= w_sb.mx_zero ? 17'd0 : w_sat_quo[16:0];
            r_h1_mx  <= w_sb.mx;
        end
    end

    // ---------------- h2: sector, remainder, reciprocal multiply ----------------
    rhsb_pkg::t_sector n_h2_sec;
    logic [12:0]       w_sec_base;
    logic [9:0]        w_rem;

    always_comb begin
        if (r_h1_hue >= 13'd4800) begin
            n_h2_sec = rhsb_pkg::SEC_5; w_sec_base = 13'd4800;
        end else if (r_h1_hue >= 13'd3840) begin
            n_h2_sec = rhsb_pkg::SEC_4; w_sec_base = 13'd3840;
        end else if (r_h1_hue >= 13'd2880) begin
            n_h2_sec = rhsb_pkg::SEC_3; w_sec_base = 13'd2880;
        end else if (r_h1_hue >= 13'd1920) begin
            n_h2_sec = rhsb_pkg::SEC_2; w_sec_base = 13'd1920;
        end else if (r_h1_hue >= 13'd960) begin
            n_h2_sec = rhsb_pkg::SEC_1; w_sec_base = 13'd960;
        end else begin
            n_h2_sec = rhsb_pkg::SEC_0; w_sec_base = 13'd0;
        end
        w_rem = 10'(r_h1_hue - w_sec_base);
    end

    logic              r_h2_vld;
    rhsb_pkg::t_sector r_h2_sec;
    logic [29:0]       r_h2_prod;
    logic [16:0]       r_h2_s;
    logic [CB-1:0]     r_h2_mx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h2_vld <= 1'b0;
        else if (w_ce) r_h2_vld <= r_h1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_h2_sec  <= n_h2_sec;
            r_h2_prod <= 30'(w_rem) * 30'(rhsb_pkg::RECIP_15);
            r_h2_s    <= r_h1_s;
            r_h2_mx   <= r_h1_mx;
        end
    end

    // ---------------- h3: fraction times saturation ----------------
    logic [15:0] w_f;
    logic [16:0] w_one_f;
    assign w_f     = r_h2_prod[28:13];
    assign w_one_f = rhsb_pkg::FRAC_ONE - {1'b0, w_f};

    logic              r_h3_vld;
    rhsb_pkg::t_sector r_h3_sec;
    logic [32:0]       r_h3_mq;
    logic [33:0]       r_h3_mt;
    logic [16:0]       r_h3_s;
    logic [CB-1:0]     r_h3_mx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h3_vld <= 1'b0;
        else if (w_ce) r_h3_vld <= r_h2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_h3_sec <= r_h2_sec;
            r_h3_mq  <= 33'(w_f) * 33'(r_h2_s);
            r_h3_mt  <= 34'(w_one_f) * 34'(r_h2_s);
            r_h3_s   <= r_h2_s;
            r_h3_mx  <= r_h2_mx;
        end
    end

    // ---------------- h4: channel scale products ----------------
    logic [16:0] w_kq, w_kt;
    assign w_kq = r_h3_mq[32:16];
    assign w_kt = r_h3_mt[32:16];

    logic              r_h4_vld;
    rhsb_pkg::t_sector r_h4_sec;
    logic [24:0]       r_h4_pp, r_h4_pq, r_h4_pt;
    logic [CB-1:0]     r_h4_mx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h4_vld <= 1'b0;
        else if (w_ce) r_h4_vld <= r_h3_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_h4_sec <= r_h3_sec;
            r_h4_pp  <= 25'(r_h3_mx) * 25'(rhsb_pkg::FRAC_ONE - r_h3_s);
            r_h4_pq  <= 25'(r_h3_mx) * 25'(rhsb_pkg::FRAC_ONE - w_kq);
            r_h4_pt  <= 25'(r_h3_mx) * 25'(rhsb_pkg::FRAC_ONE - w_kt);
            r_h4_mx  <= r_h3_mx;
        end
    end

    // ---------------- h5: sector select and gain multiply ----------------
    logic [CB-1:0] w_p, w_q, w_t, w_ro, w_go, w_bo;

    always_comb begin
        w_p = (r_h4_pp[24:16] > 9'd255) ? 8'd255 : r_h4_pp[23:16];
        w_q = (r_h4_pq[24:16] > 9'd255) ? 8'd255 : r_h4_pq[23:16];
        w_t = (r_h4_pt[24:16] > 9'd255) ? 8'd255 : r_h4_pt[23:16];
        case (r_h4_sec)
            rhsb_pkg::SEC_0: begin w_ro = r_h4_mx; w_go = w_t;     w_bo = w_p;     end
            rhsb_pkg::SEC_1: begin w_ro = w_q;     w_go = r_h4_mx; w_bo = w_p;     end
            rhsb_pkg::SEC_2: begin w_ro = w_p;     w_go = r_h4_mx; w_bo = w_t;     end
            rhsb_pkg::SEC_3: begin w_ro = w_p;     w_go = w_q;     w_bo = r_h4_mx; end
            rhsb_pkg::SEC_4: begin w_ro = w_t;     w_go = w_p;     w_bo = r_h4_mx; end
            default:         begin w_ro = r_h4_mx; w_go = w_p;     w_bo = w_q;     end
        endcase
    end

    logic        r_h5_vld;
    logic [23:0] r_h5_gr, r_h5_gg, r_h5_gb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h5_vld <= 1'b0;
        else if (w_ce) r_h5_vld <= r_h4_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_h5_gr <= 24'(w_ro) * 24'(r_gain);
            r_h5_gg <= 24'(w_go) * 24'(r_gain);
            r_h5_gb <= 24'(w_bo) * 24'(r_gain);
        end
    end

    // ---------------- output register: Q8.8 drop and saturate ----------------
    logic [CB-1:0] r_out_r, r_out_g, r_out_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (w_ce) r_out_vld <= r_h5_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_r <= (r_h5_gr[23:8] > 16'd255) ? 8'd255 : r_h5_gr[15:8];
            r_out_g <= (r_h5_gg[23:8] > 16'd255) ? 8'd255 : r_h5_gg[15:8];
            r_out_b <= (r_h5_gb[23:8] > 16'd255) ? 8'd255 : r_h5_gb[15:8];
        end
    end

    assign o_pix.valid     = r_out_vld;
    assign o_pix.red_out   = r_out_r;
    assign o_pix.green_out = r_out_g;
    assign o_pix.blue_out  = r_out_b;

    // wrapped hue stays inside one turn
    `RHSB_CHECK(a_hue_wrapped, i_clk, i_rst_n, r_h1_vld |-> (r_h1_hue < rhsb_pkg::HUE_FULL))
    // saturation never exceeds one
    `RHSB_CHECK(a_sat_le_one, i_clk, i_rst_n, r_h2_vld |-> (r_h2_s <= rhsb_pkg::FRAC_ONE))
    // a valid item moves on whenever the pipeline advances
    `RHSB_CHECK_NEXT(a_advance, i_clk, i_rst_n, r_h2_vld && w_ce, r_h3_vld)

endmodule
